// ===== rtl/wpl_pkg.sv =====
// Shared types, constants and helpers for the way-partitioned LRU block.
`timescale 1ns / 1ps

package wpl_pkg;

  localparam int WAYS      = 16;
  localparam int HALF      = WAYS / 2;
  localparam int SETS      = 2048;
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RANK_BITS = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int ROW_W     = WAYS * RANK_BITS;
  localparam int HROW_W    = HALF * RANK_BITS;
  localparam int HIDX_W    = (HALF > 1) ? $clog2(HALF) : 1;

  // Fixed field widths of the stream words
  localparam int WAY_W     = 4;
  localparam int SIDX_W    = 11;
  localparam int VMASK_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 8;

  localparam logic CMD_FIND   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_VICTIM = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_PARTITION = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Row with every way ranked by its index within its half
  function automatic logic [ROW_W-1:0] reset_row();
    logic [ROW_W-1:0] row;
    row = '0;
    for (int w = 0; w < WAYS; w++) begin
      row[w*RANK_BITS +: RANK_BITS] = RANK_BITS'((w < HALF) ? w : w - HALF);
    end
    return row;
  endfunction

  localparam logic [ROW_W-1:0] RESET_ROW = reset_row();

endpackage

// ===== rtl/wpl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/way_partitioned_lru.sv =====
// Way-partitioned LRU replacement: top level with rank memory and control.
// Each word is a read-modify-write of the set's rank row in the rank memory:
// the row is read when the word is accepted in S_IDLE, then updated, written
// and the result registered in S_EXEC once the output is free; a new word is
// taken only back in S_IDLE. Reset: rst is synchronous; afterwards a clearing pass
// writes the reset ranks into all SETS rows, one per cycle, with s_axis_tready held low.
`timescale 1ns / 1ps

module way_partitioned_lru (
  input  logic                            clk,
  input  logic                            rst,
  // Request words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: cpu[0], set_index[11:1], way[15:12], hit[16], is_writeback[17],
  //        valid_mask[33:18], zero fill [39:34]
  input  logic [wpl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: cmd[0]
  input  logic [wpl_pkg::IN_USER_W-1:0]   s_axis_tuser,
  // Result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: victim_way[3:0], status[5:4], zero fill [7:6]
  output logic [wpl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import wpl_pkg::*;

  state_t state, state_next;

  // Clearing pass counter
  logic [SET_W-1:0] clr_cnt;
  logic             clr_last;

  // Captured request word
  logic               cmd_q;
  logic               cpu_q;
  logic [SIDX_W-1:0]  set_q;
  logic [WAY_W-1:0]   way_q;
  logic               hit_q;
  logic               wb_q;
  logic [VMASK_W-1:0] vmask_q;

  // Decoded fields of the incoming word
  logic               in_cmd;
  logic               in_cpu;
  logic [SIDX_W-1:0]  in_set;
  logic [WAY_W-1:0]   in_way;
  logic               in_hit;
  logic               in_wb;
  logic [VMASK_W-1:0] in_vmask;

  // Handshake and control
  logic accept;
  logic out_free;
  logic advance;
  logic rd_en;

  // Memory ports
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] row;

  // Datapath
  logic [HROW_W-1:0]       half_row;
  logic [HROW_W-1:0]       half_row_new;
  logic [HALF-1:0]         half_valid;
  logic                    set_ok;
  logic                    way_in_half;
  logic [HIDX_W-1:0]       local_way;
  logic [RANK_BITS-1:0]    mine;
  logic                    inv_found;
  logic [HIDX_W-1:0]       inv_idx;
  logic                    old_found;
  logic [HIDX_W-1:0]       old_idx;
  logic [WAY_W-1:0]        half_base;
  logic [WAY_W-1:0]        victim;
  logic [STATUS_W-1:0]     status;
  logic                    do_write;
  logic [ROW_W-1:0]        row_new;

  assign in_cmd   = s_axis_tuser[0];
  assign in_cpu   = s_axis_tdata[0];
  assign in_set   = s_axis_tdata[11:1];
  assign in_way   = s_axis_tdata[15:12];
  assign in_hit   = s_axis_tdata[16];
  assign in_wb    = s_axis_tdata[17];
  assign in_vmask = s_axis_tdata[33:18];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign clr_last = (clr_cnt == SET_W'(SETS - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Control outputs per state
  always_comb begin
    s_axis_tready = 1'b0;
    advance       = 1'b0;
    case (state)
      S_CLEAR: ;
      S_IDLE:  s_axis_tready = 1'b1;
      S_EXEC:  advance = out_free;
      default: ;
    endcase
  end

  // Read the set's row only on accept so the read data holds through a stall
  assign rd_en = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
    end
  end

  // Capture the request word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= in_cmd;
      cpu_q   <= in_cpu;
      set_q   <= in_set;
      way_q   <= in_way;
      hit_q   <= in_hit;
      wb_q    <= in_wb;
      vmask_q <= in_vmask;
    end
  end

  wpl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_rank_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (in_set[SET_W-1:0]),
    .rdata (row)
  );

  // Select the requesting CPU's half of the row and of the valid mask
  assign half_row   = cpu_q ? row[ROW_W-1:HROW_W] : row[HROW_W-1:0];
  assign half_valid = cpu_q ? vmask_q[WAYS-1:HALF] : vmask_q[HALF-1:0];
  assign half_base  = cpu_q ? WAY_W'(HALF) : '0;

  assign set_ok = ({1'b0, set_q} < (SIDX_W + 1)'(SETS));

  // Way must lie inside the CPU's half (ways at or above WAYS never do)
  always_comb begin
    if (cpu_q) begin
      way_in_half = ({1'b0, way_q} >= (WAY_W + 1)'(HALF)) &&
                    ({1'b0, way_q} <  (WAY_W + 1)'(WAYS));
    end else begin
      way_in_half = ({1'b0, way_q} < (WAY_W + 1)'(HALF));
    end
  end

  assign local_way = HIDX_W'(way_q - half_base);
  assign mine      = half_row[local_way*RANK_BITS +: RANK_BITS];

  // Lowest invalid way and lowest oldest way within the half; scan down so
  // the lowest index wins
  always_comb begin
    inv_found = 1'b0;
    inv_idx   = '0;
    old_found = 1'b0;
    old_idx   = '0;
    for (int w = HALF - 1; w >= 0; w--) begin
      if (!half_valid[w]) begin
        inv_found = 1'b1;
        inv_idx   = HIDX_W'(w);
      end
      if (half_row[w*RANK_BITS +: RANK_BITS] == RANK_BITS'(HALF - 1)) begin
        old_found = 1'b1;
        old_idx   = HIDX_W'(w);
      end
    end
  end

  // Promote the way to rank 0 and age the ways that were younger
  always_comb begin
    logic [RANK_BITS-1:0] r;
    half_row_new = half_row;
    for (int w = 0; w < HALF; w++) begin
      r = half_row[w*RANK_BITS +: RANK_BITS];
      if (HIDX_W'(w) == local_way) begin
        half_row_new[w*RANK_BITS +: RANK_BITS] = '0;
      end else if (r < mine) begin
        half_row_new[w*RANK_BITS +: RANK_BITS] = r + RANK_BITS'(1);
      end
    end
  end

  assign row_new = cpu_q ? {half_row_new, row[HROW_W-1:0]}
                         : {row[ROW_W-1:HROW_W], half_row_new};

  // Result of the held request
  always_comb begin
    victim   = '0;
    status   = STAT_OK;
    do_write = 1'b0;
    if (cmd_q == CMD_FIND) begin
      if (!set_ok) begin
        status = STAT_NO_VICTIM;
      end else if (inv_found) begin
        victim = half_base + WAY_W'(inv_idx);
      end else if (old_found) begin
        victim = half_base + WAY_W'(old_idx);
      end else begin
        status = STAT_NO_VICTIM;
      end
    end else begin
      // Writeback hits leave the state alone and skip the partition check
      if (hit_q && wb_q) begin
        status = STAT_OK;
      end else if (!way_in_half) begin
        status = STAT_PARTITION;
      end else begin
        do_write = set_ok;
      end
    end
  end

  // Write port: reset ranks during the clearing pass, else the updated row
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = RESET_ROW;
    end else begin
      ram_we    = advance && do_write;
      ram_waddr = set_q[SET_W-1:0];
      ram_wdata = row_new;
    end
  end

  // Output register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {2'b00, status, victim};
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the way-partitioned LRU block: directed and random stream traffic.
`timescale 1ns / 1ps

module tb_top;
  import wpl_pkg::*;

  // Generous run limit: the clearing pass plus every word at its slowest gap and stall,
  // taken several times over
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic                 cmd;
    logic                 cpu;
    logic [SIDX_W-1:0]    set_index;
    logic [WAY_W-1:0]     way;
    logic                 hit;
    logic                 wb;
    logic [VMASK_W-1:0]   valid_mask;
  } lru_req_t;

  typedef struct packed {
    logic [WAY_W-1:0]    victim;
    logic [STATUS_W-1:0] status;
  } lru_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Predictor state: one rank row per set, 3 bits per way, way w in bits 3w+2..3w
  logic [ROW_W-1:0] rank_rows [SETS];
  lru_result_t      pending_results [$];
  int               error_count   = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               stall_left    = 0;
  int               cycle_count   = 0;
  logic [SIDX_W-1:0] hot_sets [4];

  way_partitioned_lru dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    if (error_count < PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Reset ranks: each way ranked by its index within its half
  task automatic clear_ranks();
    logic [ROW_W-1:0] row;
    row = '0;
    for (int w = 0; w < WAYS; w++) row[w*3 +: 3] = 3'(w % HALF);
    for (int s = 0; s < SETS; s++) rank_rows[s] = row;
  endtask

  // Work out the result of one accepted word and advance the rank rows
  function automatic lru_result_t replace_decision(input lru_req_t r);
    lru_result_t      res;
    logic [ROW_W-1:0] row;
    int               lo;
    logic [2:0]       mine;
    logic [2:0]       cur;
    logic             found;
    res   = '0;
    lo    = r.cpu ? HALF : 0;
    row   = rank_rows[r.set_index];
    found = 1'b0;
    if (r.cmd == CMD_FIND) begin
      // First invalid way in the half wins, then the oldest-ranked way
      for (int w = lo; w < lo + HALF; w++) begin
        if (!found && !r.valid_mask[w]) begin
          res.victim = WAY_W'(w);
          found = 1'b1;
        end
      end
      for (int w = lo; w < lo + HALF; w++) begin
        if (!found && row[w*3 +: 3] == 3'(HALF - 1)) begin
          res.victim = WAY_W'(w);
          found = 1'b1;
        end
      end
      if (!found) begin
        res.victim = '0;
        res.status = STAT_NO_VICTIM;
      end
    end else if (r.hit && r.wb) begin
      res.status = STAT_OK;
    end else if (int'(r.way) < lo || int'(r.way) >= lo + HALF) begin
      res.status = STAT_PARTITION;
    end else begin
      // Promote the way to rank 0, age every younger way of the half
      mine = row[r.way*3 +: 3];
      for (int w = lo; w < lo + HALF; w++) begin
        cur = row[w*3 +: 3];
        if (cur < mine) row[w*3 +: 3] = cur + 3'd1;
      end
      row[r.way*3 +: 3] = 3'd0;
      rank_rows[r.set_index] = row;
    end
    return res;
  endfunction

  // Offer one word, idling at random first; record the prediction on acceptance
  task automatic send_req(input lru_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= {6'b0, r.valid_mask, r.wb, r.hit, r.way, r.set_index, r.cpu};
    forever begin
      @(posedge clk);
      if (s_axis_tready) break;
    end
    pending_results.push_back(replace_decision(r));
  endtask

  // Drop valid once a test has nothing more to offer
  task automatic stop_sending();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic find_req(input logic cpu, input int set_index, input logic [15:0] mask);
    lru_req_t r;
    r = '{cmd: CMD_FIND, cpu: cpu, set_index: SIDX_W'(set_index), way: '0,
          hit: 1'b0, wb: 1'b0, valid_mask: mask};
    send_req(r);
  endtask

  task automatic update_req(input logic cpu, input int set_index, input int way,
                            input logic hit, input logic wb);
    lru_req_t r;
    r = '{cmd: CMD_UPDATE, cpu: cpu, set_index: SIDX_W'(set_index), way: WAY_W'(way),
          hit: hit, wb: wb, valid_mask: '0};
    send_req(r);
  endtask

  // Fresh sets, all ways valid: the oldest way of each half is its last one
  task automatic test_reset_victims();
    find_req(1'b0, 0, 16'hFFFF);
    find_req(1'b1, SETS - 1, 16'hFFFF);
    stop_sending();
  endtask

  // Invalid ways win over rank; bits of the other half are ignored
  task automatic test_invalid_ways();
    find_req(1'b0, 3, 16'hFFFE);
    find_req(1'b0, 3, 16'h00FF);
    find_req(1'b1, 3, 16'h7FFF);
    find_req(1'b1, 3, 16'h0000);
    find_req(1'b0, 3, 16'hFFBF);
    stop_sending();
  endtask

  // Promotion and aging within one half, checked through the next victim
  task automatic test_update_aging();
    update_req(1'b0, 5, 7, 1'b0, 1'b0);
    find_req(1'b0, 5, 16'hFFFF);
    update_req(1'b1, 5, 8, 1'b1, 1'b0);
    update_req(1'b1, 5, 15, 1'b1, 1'b0);
    find_req(1'b1, 5, 16'hFFFF);
    update_req(1'b0, 5, 0, 1'b1, 1'b0);
    find_req(1'b0, 5, 16'hFFFF);
    stop_sending();
  endtask

  // Writeback hit leaves ranks alone and skips the partition check;
  // a writeback fill updates as usual
  task automatic test_writeback_hit();
    update_req(1'b0, 9, 15, 1'b1, 1'b1);
    find_req(1'b0, 9, 16'hFFFF);
    update_req(1'b0, 9, 7, 1'b0, 1'b1);
    find_req(1'b0, 9, 16'hFFFF);
    stop_sending();
  endtask

  // Ways outside the requesting core's half are flagged and change nothing
  task automatic test_partition_mismatch();
    update_req(1'b0, 11, 8, 1'b1, 1'b0);
    update_req(1'b0, 11, 15, 1'b0, 1'b0);
    update_req(1'b1, 11, 0, 1'b0, 1'b1);
    update_req(1'b1, 11, 7, 1'b1, 1'b0);
    find_req(1'b1, 11, 16'hFFFF);
    stop_sending();
  endtask

  // Mostly well-formed traffic on a few hot sets so the ranks evolve and
  // back-to-back accesses hit the same row; the rest is noise
  task automatic test_random_traffic(input int count, input int s_idle, input int r_idle);
    lru_req_t r;
    int       pick;
    int       mask_kind;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < count; i++) begin
      r.cpu        = 1'($urandom_range(1));
      r.set_index  = ($urandom_range(99) < 80) ? hot_sets[$urandom_range(3)]
                                                : SIDX_W'($urandom_range(SETS - 1));
      r.way        = WAY_W'($urandom_range(15));
      r.hit        = 1'($urandom_range(1));
      r.wb         = 1'($urandom_range(1));
      r.valid_mask = VMASK_W'($urandom_range(16'hFFFF));
      pick         = $urandom_range(99);
      if (pick < 45) begin
        // Hit or fill inside the core's own half
        r.cmd = CMD_UPDATE;
        r.way = {r.cpu, 3'($urandom_range(7))};
        if (r.hit) r.wb = 1'b0;
      end else if (pick < 52) begin
        r.cmd = CMD_UPDATE;
        r.hit = 1'b1;
        r.wb  = 1'b1;
      end else if (pick < 60) begin
        r.cmd = CMD_UPDATE;
        r.way = {~r.cpu, 3'($urandom_range(7))};
        if (r.hit) r.wb = 1'b0;
      end else begin
        r.cmd     = CMD_FIND;
        mask_kind = $urandom_range(9);
        if (mask_kind < 7) r.valid_mask = 16'hFFFF;
        else if (mask_kind == 7) r.valid_mask = 16'hFFFF ^ (16'h1 << $urandom_range(15));
      end
      send_req(r);
    end
    stop_sending();
  endtask

  // Hold the result side off for a long stretch while words keep coming,
  // so the block fills and deasserts s_axis_tready
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left    = 400;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 2) find_req(1'($urandom_range(1)), hot_sets[i % 4], 16'hFFFF);
      else update_req(1'($urandom_range(1)), hot_sets[i % 4], $urandom_range(15),
                      1'b1, 1'b0);
    end
    stop_sending();
  endtask

  // Result side: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    lru_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result word %h with no prediction waiting", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[3:0] !== want.victim)
          flag_error($sformatf("victim_way %0d, predicted %0d", m_axis_tdata[3:0], want.victim));
        if (m_axis_tdata[5:4] !== want.status)
          flag_error($sformatf("status %0d, predicted %0d", m_axis_tdata[5:4], want.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clear_ranks();
    hot_sets[0] = '0;
    hot_sets[1] = SIDX_W'(SETS - 1);
    hot_sets[2] = SIDX_W'($urandom_range(SETS - 1));
    hot_sets[3] = SIDX_W'($urandom_range(SETS - 1));
    // Hold reset, then release it at a falling edge; the clearing pass then keeps tready low
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_victims();
    test_invalid_ways();
    test_update_aging();
    test_writeback_hit();
    test_partition_mismatch();
    test_random_traffic(590, 38, 79);
    test_random_traffic(590, 79, 38);
    test_backpressure();
    test_random_traffic(590, 0, 0);

    // Drain, then wait on for any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
